@@ design/assert_macros.svh @@
// Assertion macros used by the checker of the timer bank.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is applied.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Clocked assertion that also holds while reset is applied.
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

@@ design/ttsb_pkg.sv @@
// Package for the tick timer and stopwatch bank: item types, codes and constants.
package ttsb_pkg;

  // Default unit counts
  localparam int unsigned NumTimers   = 2;
  localparam int unsigned NumCounters = 2;

  // Scaling constants
  localparam int unsigned MsFactor = 1000;
  localparam int unsigned SFactor  = 1000 * 1000;
  localparam int unsigned SClamp   = 4293;

  // Widths of the running quotient and remainder trackers in a stopwatch
  localparam int unsigned MsRemW  = 10;  // holds 0..999
  localparam int unsigned MsQuotW = 23;  // holds up to 2^32/1000
  localparam int unsigned SRemW   = 20;  // holds 0..999999
  localparam int unsigned SQuotW  = 13;  // holds up to 2^32/1000000
  localparam int unsigned ClampW  = 13;  // holds the seconds clamp
  localparam int unsigned DelayW  = 42;

  // Configuration port
  localparam int unsigned CfgAddrW = 3;
  localparam logic        CfgIdxTickIsUs = 1'b0;  // register index, paddr[2]

  typedef enum logic [1:0] {
    FUNC_TICK    = 2'd0,
    FUNC_TIMER   = 2'd1,
    FUNC_COUNTER = 2'd2,
    FUNC_DELAY   = 2'd3
  } ttsb_func_e;

  typedef enum logic [2:0] {
    CMD_STOP     = 3'd0,
    CMD_START_US = 3'd1,
    CMD_START_MS = 3'd2,
    CMD_START_S  = 3'd3,
    CMD_CHECK    = 3'd4
  } ttsb_cmd_e;

  typedef enum logic [1:0] {
    SCALE_NONE = 2'd0,
    SCALE_US   = 2'd1,
    SCALE_MS   = 2'd2,
    SCALE_S    = 2'd3
  } ttsb_scale_e;

  // Input item
  typedef struct packed {
    logic [1:0]  func;
    logic        unit;
    logic [2:0]  cmd;
    logic [31:0] amount;
  } ttsb_in_t;

  // Result item
  typedef struct packed {
    logic        timer_running;
    logic [31:0] elapsed;
    logic        delay_busy;
  } ttsb_out_t;

  // Update request for one countdown timer
  typedef struct packed {
    logic        tick;
    logic        hold;
    logic        load;
    logic [31:0] value;
  } ttsb_tmr_op_t;

  // Update request for one stopwatch
  typedef struct packed {
    logic       tick;
    logic       halt;
    logic       start;
    logic [1:0] scale;
  } ttsb_cnt_op_t;

endpackage

@@ design/ttsb_timer.sv @@
// One countdown timer: decrements on a tick, loads on start, holds at one on stop.
module ttsb_timer
  import ttsb_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  ttsb_tmr_op_t op_i,
  output logic         nonzero_o
);

  logic [31:0] left_q, left_d;

  assign nonzero_o = (left_q != 32'd0);

  // Next count
  always_comb begin
    left_d = left_q;
    if (op_i.load) begin
      left_d = op_i.value;
    end else if (op_i.hold) begin
      left_d = 32'd1;
    end else if (op_i.tick && nonzero_o) begin
      left_d = left_q - 32'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
    end else begin
      left_q <= left_d;
    end
  end

endmodule

@@ design/ttsb_counter.sv @@
// One stopwatch: tick count plus running quotients by 1000 and 1000000.
module ttsb_counter
  import ttsb_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  ttsb_cnt_op_t op_i,
  input  logic         tick_is_us_i,
  output logic [31:0]  elapsed_o
);

  logic [31:0]        value_q, value_d;
  logic               running_q, running_d;
  logic [1:0]         scale_q, scale_d;
  logic [MsRemW-1:0]  ms_rem_q, ms_rem_d;
  logic [MsQuotW-1:0] ms_quot_q, ms_quot_d;
  logic [SRemW-1:0]   s_rem_q, s_rem_d;
  logic [SQuotW-1:0]  s_quot_q, s_quot_d;

  // State update; quotient and remainder track value, clearing on 32-bit wrap
  always_comb begin
    value_d   = value_q;
    running_d = running_q;
    scale_d   = scale_q;
    ms_rem_d  = ms_rem_q;
    ms_quot_d = ms_quot_q;
    s_rem_d   = s_rem_q;
    s_quot_d  = s_quot_q;
    if (op_i.start) begin
      value_d   = '0;
      running_d = 1'b1;
      scale_d   = op_i.scale;
      ms_rem_d  = '0;
      ms_quot_d = '0;
      s_rem_d   = '0;
      s_quot_d  = '0;
    end else if (op_i.halt) begin
      running_d = 1'b0;
    end else if (op_i.tick && running_q) begin
      value_d = value_q + 32'd1;
      if (value_q == '1) begin
        ms_rem_d  = '0;
        ms_quot_d = '0;
        s_rem_d   = '0;
        s_quot_d  = '0;
      end else begin
        if (ms_rem_q == MsRemW'(MsFactor - 1)) begin
          ms_rem_d  = '0;
          ms_quot_d = ms_quot_q + MsQuotW'(1);
        end else begin
          ms_rem_d = ms_rem_q + MsRemW'(1);
        end
        if (s_rem_q == SRemW'(SFactor - 1)) begin
          s_rem_d  = '0;
          s_quot_d = s_quot_q + SQuotW'(1);
        end else begin
          s_rem_d = s_rem_q + SRemW'(1);
        end
      end
    end
  end

  // Elapsed time in the started unit for the current tick length
  always_comb begin
    case (ttsb_scale_e'(scale_q))
      SCALE_NONE: elapsed_o = '0;
      SCALE_US:   elapsed_o = value_q;
      SCALE_MS:   elapsed_o = tick_is_us_i ? 32'(ms_quot_q) : value_q;
      SCALE_S:    elapsed_o = tick_is_us_i ? 32'(s_quot_q) : 32'(ms_quot_q);
      default:    elapsed_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q   <= '0;
      running_q <= 1'b0;
      scale_q   <= '0;
      ms_rem_q  <= '0;
      ms_quot_q <= '0;
      s_rem_q   <= '0;
      s_quot_q  <= '0;
    end else begin
      value_q   <= value_d;
      running_q <= running_d;
      scale_q   <= scale_d;
      ms_rem_q  <= ms_rem_d;
      ms_quot_q <= ms_quot_d;
      s_rem_q   <= s_rem_d;
      s_quot_q  <= s_quot_d;
    end
  end

endmodule

@@ design/tick_timer_and_stopwatch_bank.sv @@
// Top level of the tick timer and stopwatch bank: handshake stages, decode and delay.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-------------------------------------
//   input    | in_valid_i / in_stall_o   | in_data_i  (func, unit, cmd, amount)
//   result   | out_valid_o / out_stall_i | out_data_o (timer_running, elapsed,
//            |                           |             delay_busy)
//   config   | APB psel/penable/pwrite   | paddr, pwdata, prdata
//
// One item a cycle while the result is not stalled; an accepted item passes
// through the input register and then the output register.
// An item sits in the input register and is applied to all units in one pass
// whose result lands in the output register.
// A stalled result holds the output register; one more item waits in the
// input register before in_stall_o rises.
// Reset clears all counts, the delay and the handshake stages; tick_is_us
// resets to one.
module tick_timer_and_stopwatch_bank
  import ttsb_pkg::*;
#(
  parameter int unsigned NUM_TIMERS   = NumTimers,
  parameter int unsigned NUM_COUNTERS = NumCounters
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ttsb_in_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ttsb_out_t           out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // Handshake stages
  ttsb_in_t  in_q;
  logic      in_valid_q, in_valid_d;
  ttsb_out_t out_q, out_d;
  logic      out_valid_q, out_valid_d;
  logic      adv, fire, in_accept;

  // Configuration and delay state
  logic              tick_is_us_q;
  logic [DelayW-1:0] delay_q, delay_d;

  // Decode
  logic              is_tick, is_timer, is_counter, is_delay;
  logic              start_ok;
  logic [DelayW-1:0] amt_x1000;
  logic [ClampW-1:0] amt_clamped;
  logic [31:0]       amt_x1e6;
  logic [31:0]       load_value;

  // Unit selection and status
  logic [NUM_TIMERS-1:0]   tmr_sel, tmr_nz;
  logic [NUM_COUNTERS-1:0] cnt_sel;
  logic [31:0]             cnt_elapsed [NUM_COUNTERS];
  logic                    tmr_any, tmr_nz_sel, cnt_any;
  logic [31:0]             elapsed_sel;

  // Pipeline flow
  assign adv        = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && adv;
  assign in_stall_o = in_valid_q && !adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Command decode
  assign is_tick    = fire && (in_q.func == FUNC_TICK);
  assign is_timer   = fire && (in_q.func == FUNC_TIMER);
  assign is_counter = fire && (in_q.func == FUNC_COUNTER);
  assign is_delay   = fire && (in_q.func == FUNC_DELAY);

  assign start_ok = ((in_q.cmd == CMD_START_US) && tick_is_us_q)
                 || (in_q.cmd == CMD_START_MS) || (in_q.cmd == CMD_START_S);

  // Scaled start values; the products fit their width, the timer load keeps the low 32 bits
  assign amt_x1000   = {{(DelayW-32){1'b0}}, in_q.amount} * DelayW'(MsFactor);
  assign amt_clamped = (in_q.amount > 32'(SClamp)) ? ClampW'(SClamp)
                                                    : in_q.amount[ClampW-1:0];
  assign amt_x1e6    = {19'b0, amt_clamped} * 32'(SFactor);

  always_comb begin
    case (ttsb_cmd_e'(in_q.cmd))
      CMD_START_MS: load_value = tick_is_us_q ? amt_x1000[31:0] : in_q.amount;
      CMD_START_S:  load_value = tick_is_us_q ? amt_x1e6 : amt_x1000[31:0];
      default:      load_value = in_q.amount;
    endcase
  end

  // Countdown timers
  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_tmr
    localparam logic [4:0] Idx = 5'(i);
    ttsb_tmr_op_t op;

    assign tmr_sel[i] = ({4'b0, in_q.unit} == Idx);
    assign op.tick    = is_tick;
    assign op.hold    = is_timer && tmr_sel[i] && (in_q.cmd == CMD_STOP);
    assign op.load    = is_timer && tmr_sel[i] && start_ok;
    assign op.value   = load_value;

    ttsb_timer u_timer (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .op_i      (op),
      .nonzero_o (tmr_nz[i])
    );
  end

  // Stopwatches
  for (genvar i = 0; i < NUM_COUNTERS; i++) begin : g_cnt
    localparam logic [4:0] Idx = 5'(i);
    ttsb_cnt_op_t op;

    assign cnt_sel[i] = ({4'b0, in_q.unit} == Idx);
    assign op.tick    = is_tick;
    assign op.halt    = is_counter && cnt_sel[i] && (in_q.cmd == CMD_STOP);
    assign op.start   = is_counter && cnt_sel[i] && start_ok;
    assign op.scale   = in_q.cmd[1:0];

    ttsb_counter u_counter (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .op_i         (op),
      .tick_is_us_i (tick_is_us_q),
      .elapsed_o    (cnt_elapsed[i])
    );
  end

  // Status of the addressed unit
  always_comb begin
    tmr_any     = 1'b0;
    tmr_nz_sel  = 1'b0;
    cnt_any     = 1'b0;
    elapsed_sel = '0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      tmr_any    = tmr_any | tmr_sel[i];
      tmr_nz_sel = tmr_nz_sel | (tmr_sel[i] & tmr_nz[i]);
    end
    for (int i = 0; i < NUM_COUNTERS; i++) begin
      cnt_any     = cnt_any | cnt_sel[i];
      elapsed_sel = elapsed_sel | (cnt_elapsed[i] & {32{cnt_sel[i]}});
    end
  end

  // Delay countdown
  always_comb begin
    delay_d = delay_q;
    if (is_delay) begin
      delay_d = tick_is_us_q ? amt_x1000 : {{(DelayW-32){1'b0}}, in_q.amount};
    end else if (is_tick && (delay_q != '0)) begin
      delay_d = delay_q - DelayW'(1);
    end
  end

  // Result item
  always_comb begin
    out_d               = out_q;
    out_d.timer_running = 1'b0;
    out_d.elapsed       = '0;
    out_d.delay_busy    = (delay_d != '0);
    if ((in_q.func == FUNC_TIMER) && tmr_any) begin
      if (in_q.cmd == CMD_STOP) begin
        out_d.timer_running = 1'b0;
      end else if (start_ok) begin
        out_d.timer_running = 1'b1;
      end else begin
        out_d.timer_running = tmr_nz_sel;
      end
    end
    if ((in_q.func == FUNC_COUNTER) && cnt_any && (in_q.cmd == CMD_CHECK)) begin
      out_d.elapsed = elapsed_sel;
    end
  end

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == CfgIdxTickIsUs) ? {31'b0, tick_is_us_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_is_us_q <= 1'b1;
    end else if (psel && penable && pwrite && pready && (paddr[2] == CfgIdxTickIsUs)) begin
      tick_is_us_q <= pwdata[0];
    end
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      delay_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      delay_q     <= delay_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ design/ttsb_checker.sv @@
// Port-level checks for the tick timer and stopwatch bank, bound to the top level.
`include "assert_macros.svh"

module ttsb_checker
  import ttsb_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input ttsb_out_t out_data_o
);

  // A held result stays put
  `ASSERT_CLK(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o), "result changed while stalled")

  // Input only backs up behind a waiting result
  `ASSERT_CLK_ALWAYS(a_stall_cause, in_stall_o |-> out_valid_o, "input stalled with output empty")

  // An item taken with the output empty leads to a valid result once through the input and output registers
  `ASSERT_CLK(a_latency, in_valid_i && !in_stall_o && !out_valid_o |-> ##2 out_valid_o, "accepted item produced no result")

  // Timer status and elapsed time never come from the same item
  `ASSERT_CLK(a_excl, out_valid_o |-> !(out_data_o.timer_running && (out_data_o.elapsed != 32'd0)), "timer and counter fields both set")

endmodule

bind tick_timer_and_stopwatch_bank ttsb_checker u_ttsb_checker (.*);
